FILE: hdl/stiffness_matrix_product_assert.svh
// ---------------------------------------------------------------------------
// stiffness matrix product assertion macros
// concurrent checks sampled on clock, disabled while reset is high
// ---------------------------------------------------------------------------
`ifndef STIFFNESS_MATRIX_PRODUCT_ASSERT_SVH
`define STIFFNESS_MATRIX_PRODUCT_ASSERT_SVH

// same-cycle implication
`define SMP_ASSERT_NOW(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (conseq)) \
      else $error(msg);

// next-cycle implication
`define SMP_ASSERT_NEXT(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error(msg);

`endif

FILE: hdl/smp_pkg.sv
// ---------------------------------------------------------------------------
// smp_pkg
// shared constants and types of the stiffness matrix product block
// ---------------------------------------------------------------------------
package smp_pkg;

   localparam int MAX_SIZE   = 8;
   localparam int CELLS      = MAX_SIZE * MAX_SIZE;
   localparam int ADDR_W     = $clog2(CELLS);
   localparam int IDX_W      = 3;
   localparam int SIZE_W     = 4;
   localparam int DATA_W     = 32;
   localparam int PROD_W     = 2 * DATA_W;
   localparam int ACC_W      = PROD_W + IDX_W;
   localparam int FRAC_BITS  = 20;
   localparam int CMD_W      = 2;

   localparam logic [CMD_W-1:0] CMD_WRITE_MASS    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE_INVMASS = 2'd1;
   localparam logic [CMD_W-1:0] CMD_WRITE_DERIV   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_COMPUTE       = 2'd3;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_SIZE);

   // tag that travels with each multiply-accumulate through the pipeline
   typedef struct packed {
      logic             first;
      logic             last;
      logic             fin;
      logic             phase_s;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } tag_type;

   function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] r,
                                                 input logic [IDX_W-1:0] c);
      addr_of = ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_SIZE) + ADDR_W'(c));
   endfunction

endpackage

FILE: hdl/stiffness_matrix_product.sv
// ---------------------------------------------------------------------------
// stiffness_matrix_product
// loads mass, inverse mass and derivative matrices, then forms
// T = M*D and S = Minv*T^T in Q12.20 and streams S out in row-major order
// ---------------------------------------------------------------------------
//
// channel    ports                                         handshake
// request    req_command, req_row, req_col, req_value      start & !busy
// response   rsp_out_row, rsp_out_col, rsp_out_value,       rsp_valid strobe,
//            rsp_last                                      one cycle, no stall
// csr        csr_wr_data (size_in_use)                     csr_wr_en
//
// a load transaction writes its memory directly and busy stays low
// compute keeps busy high until both passes finish: one multiply-accumulate per
// cycle through a single 32x32 multiplier fed from one read port per memory
// each of the two passes drains the pipeline before moving on
// the last element of S comes out in the final busy cycle
// reset is synchronous active high; clears control state and sets size to 8
// the response side cannot stall: each rsp_valid pulse is one transaction
// ---------------------------------------------------------------------------
`include "stiffness_matrix_product_assert.svh"

module stiffness_matrix_product (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [smp_pkg::CMD_W-1:0]           req_command,
   input  logic [smp_pkg::IDX_W-1:0]           req_row,
   input  logic [smp_pkg::IDX_W-1:0]           req_col,
   input  logic signed [smp_pkg::DATA_W-1:0]   req_value,
   input  logic                                csr_wr_en,
   input  logic [smp_pkg::SIZE_W-1:0]          csr_wr_data,
   output logic                                rsp_valid,
   output logic [smp_pkg::IDX_W-1:0]           rsp_out_row,
   output logic [smp_pkg::IDX_W-1:0]           rsp_out_col,
   output logic signed [smp_pkg::DATA_W-1:0]   rsp_out_value,
   output logic                                rsp_last
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_T_RUN   = 3'd1;
   localparam logic [2:0] ST_T_DRAIN = 3'd2;
   localparam logic [2:0] ST_S_RUN   = 3'd3;
   localparam logic [2:0] ST_S_DRAIN = 3'd4;

   localparam int DATA_W = smp_pkg::DATA_W;
   localparam int ACC_W  = smp_pkg::ACC_W;
   localparam int IDX_W  = smp_pkg::IDX_W;
   localparam int ADDR_W = smp_pkg::ADDR_W;
   localparam int FRAC   = smp_pkg::FRAC_BITS;

   // matrix memories
   logic signed [DATA_W-1:0] mass_mem  [smp_pkg::CELLS];
   logic signed [DATA_W-1:0] invm_mem  [smp_pkg::CELLS];
   logic signed [DATA_W-1:0] deriv_mem [smp_pkg::CELLS];
   logic signed [DATA_W-1:0] prod_mem  [smp_pkg::CELLS];

   // control state
   logic [smp_pkg::SIZE_W-1:0] size_ff;
   logic [2:0]                 state_ff, state_in;
   logic [IDX_W-1:0]           i_ff, i_in, j_ff, j_in, k_ff, k_in;

   // pipeline: read, multiply, accumulate
   logic                       s1_vld_ff, s2_vld_ff, s3_vld_ff;
   smp_pkg::tag_type           s1_tag_ff, s2_tag_ff, s3_tag_ff, issue_tag;
   logic signed [DATA_W-1:0]   mass_rd_ff, invm_rd_ff, deriv_rd_ff, prod_rd_ff;
   logic signed [DATA_W-1:0]   opa, opb;
   logic signed [smp_pkg::PROD_W-1:0] mul_ff;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;

   // rounding and saturation
   logic signed [ACC_W-1:0]    rnd_sum;
   logic [ACC_W-FRAC-DATA_W:0] rnd_hi;
   logic signed [DATA_W-1:0]   rnd_val;

   logic                       accept, issue, pipe_empty, load_ok;
   logic [IDX_W-1:0]           nm1;
   logic [ADDR_W-1:0]          addr_a, addr_b, load_addr, wb_addr;

   logic                       rsp_valid_ff, rsp_last_ff;
   logic [IDX_W-1:0]           rsp_row_ff, rsp_col_ff;
   logic signed [DATA_W-1:0]   rsp_value_ff;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign issue      = (state_ff == ST_T_RUN) || (state_ff == ST_S_RUN);
   assign pipe_empty = !s1_vld_ff && !s2_vld_ff && !s3_vld_ff;

   // effective size: zero acts as one, above the store acts as the store size
   always_comb begin
      if (size_ff == '0) begin
         nm1 = '0;
      end else if (size_ff > smp_pkg::SIZE_W'(smp_pkg::MAX_SIZE)) begin
         nm1 = IDX_W'(smp_pkg::MAX_SIZE - 1);
      end else begin
         nm1 = IDX_W'(size_ff - 1'b1);
      end
   end

   // size register
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= smp_pkg::SIZE_RESET;
      end else if (csr_wr_en) begin
         size_ff <= csr_wr_data;
      end
   end

   // sequencer: walk i, j, k for each pass, then wait for the pipeline to empty
   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      unique case (state_ff)
         ST_IDLE: begin
            i_in = '0;
            j_in = '0;
            k_in = '0;
            if (accept && req_command == smp_pkg::CMD_COMPUTE) begin
               state_in = ST_T_RUN;
            end
         end
         ST_T_RUN, ST_S_RUN: begin
            if (k_ff != nm1) begin
               k_in = k_ff + 1'b1;
            end else begin
               k_in = '0;
               if (j_ff != nm1) begin
                  j_in = j_ff + 1'b1;
               end else begin
                  j_in = '0;
                  if (i_ff != nm1) begin
                     i_in = i_ff + 1'b1;
                  end else begin
                     i_in     = '0;
                     state_in = (state_ff == ST_T_RUN) ? ST_T_DRAIN : ST_S_DRAIN;
                  end
               end
            end
         end
         ST_T_DRAIN: begin
            // every element of T is written back before the second pass reads it
            if (pipe_empty) begin
               state_in = ST_S_RUN;
            end
         end
         ST_S_DRAIN: begin
            if (pipe_empty) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

   // read addresses: first pass M(i,k) and D(k,j), second pass Minv(i,k) and T(j,k)
   always_comb begin
      addr_a = smp_pkg::addr_of(i_ff, k_ff);
      if (state_ff == ST_S_RUN) begin
         addr_b = smp_pkg::addr_of(j_ff, k_ff);
      end else begin
         addr_b = smp_pkg::addr_of(k_ff, j_ff);
      end
      issue_tag.first   = (k_ff == '0);
      issue_tag.last    = (k_ff == nm1);
      issue_tag.fin     = (i_ff == nm1) && (j_ff == nm1);
      issue_tag.phase_s = (state_ff == ST_S_RUN);
      issue_tag.row     = i_ff;
      issue_tag.col     = j_ff;
   end

   // load transactions write straight into the matrix memories
   assign load_addr = smp_pkg::addr_of(req_row, req_col);
   assign load_ok   = accept && (32'(req_row) < smp_pkg::MAX_SIZE)
                      && (32'(req_col) < smp_pkg::MAX_SIZE);

   always_ff @(posedge clock) begin
      if (load_ok && req_command == smp_pkg::CMD_WRITE_MASS) begin
         mass_mem[load_addr] <= req_value;
      end
      mass_rd_ff <= mass_mem[addr_a];
   end

   always_ff @(posedge clock) begin
      if (load_ok && req_command == smp_pkg::CMD_WRITE_INVMASS) begin
         invm_mem[load_addr] <= req_value;
      end
      invm_rd_ff <= invm_mem[addr_a];
   end

   always_ff @(posedge clock) begin
      if (load_ok && req_command == smp_pkg::CMD_WRITE_DERIV) begin
         deriv_mem[load_addr] <= req_value;
      end
      deriv_rd_ff <= deriv_mem[addr_b];
   end

   // T is written back by the first pass and only read in the second
   assign wb_addr = smp_pkg::addr_of(s3_tag_ff.row, s3_tag_ff.col);

   always_ff @(posedge clock) begin
      if (s3_vld_ff && !s3_tag_ff.phase_s) begin
         prod_mem[wb_addr] <= rnd_val;
      end
      prod_rd_ff <= prod_mem[addr_b];
   end

   // operand select after the memory read
   assign opa = s1_tag_ff.phase_s ? invm_rd_ff : mass_rd_ff;
   assign opb = s1_tag_ff.phase_s ? prod_rd_ff : deriv_rd_ff;

   // accumulate at full width, restart on the first term of each dot product
   assign acc_in = s2_tag_ff.first ? ACC_W'(mul_ff) : acc_ff + ACC_W'(mul_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= issue;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff && s2_tag_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      s1_tag_ff <= issue_tag;
      s2_tag_ff <= s1_tag_ff;
      s3_tag_ff <= s2_tag_ff;
      mul_ff    <= opa * opb;
      if (s2_vld_ff) begin
         acc_ff <= acc_in;
      end
   end

   // round half up to Q12.20, then saturate to 32 bits
   always_comb begin
      rnd_sum = acc_ff + ACC_W'(1 << (FRAC - 1));
      rnd_hi  = rnd_sum[ACC_W-1:FRAC+DATA_W-1];
      if ((&rnd_hi) || !(|rnd_hi)) begin
         rnd_val = rnd_sum[FRAC+DATA_W-1:FRAC];
      end else if (rnd_sum[ACC_W-1]) begin
         rnd_val = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         rnd_val = {1'b0, {(DATA_W-1){1'b1}}};
      end
   end

   // response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s3_vld_ff && s3_tag_ff.phase_s;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_vld_ff && s3_tag_ff.phase_s) begin
         rsp_row_ff   <= s3_tag_ff.row;
         rsp_col_ff   <= s3_tag_ff.col;
         rsp_value_ff <= rnd_val;
         rsp_last_ff  <= s3_tag_ff.fin;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_out_col   = rsp_col_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_last      = rsp_valid_ff && rsp_last_ff;

   // checks
   `SMP_ASSERT_NOW(a_rsp_while_busy, rsp_valid, busy, "response outside compute")
   `SMP_ASSERT_NEXT(a_compute_starts, start && !busy && req_command == smp_pkg::CMD_COMPUTE,
      busy, "compute did not start")
   `SMP_ASSERT_NOW(a_no_wb_in_s_pass, s3_vld_ff && !s3_tag_ff.phase_s,
      state_ff != ST_S_RUN, "product write back overlaps second pass")
   `SMP_ASSERT_NOW(a_idle_pipe_empty, state_ff == ST_IDLE, pipe_empty,
      "pipeline busy while idle")

endmodule

FILE: test/stiffness_matrix_product_tb.sv
// ---------------------------------------------------------------------------
// stiffness_matrix_product_tb
// self-checking bench: loads mass, inverse mass and derivative matrices,
// issues compute commands at many sizes and checks every streamed element
// of S = Minv * (M*D)^T against a bit-exact Q12.20 predictor
// ---------------------------------------------------------------------------
module stiffness_matrix_product_tb;

   localparam int DATA_W    = smp_pkg::DATA_W;
   localparam int IDX_W     = smp_pkg::IDX_W;
   localparam int SIZE_W    = smp_pkg::SIZE_W;
   localparam int CMD_W     = smp_pkg::CMD_W;
   localparam int MAX_SIZE  = smp_pkg::MAX_SIZE;
   localparam int CELLS     = smp_pkg::CELLS;
   localparam int FRAC_BITS = smp_pkg::FRAC_BITS;

   typedef logic signed [DATA_W-1:0] q_type;

   // one element of the stiffness matrix as it leaves the block
   typedef struct {
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      q_type            value;
      logic             last;
   } stiffness_elem_type;

   localparam int    WIDE_W       = 72;     // room for eight 64-bit products
   localparam int    TARGET_ITEMS = 430;
   localparam int    CFG_SETTLE   = 16;     // quiet cycles before a size write
   localparam int    END_WAIT     = 1100;   // about one full compute at size 8
   localparam int    LIMIT        = 20000;  // cycles without any transaction
   localparam q_type Q_MAX        = 32'sh7FFF_FFFF;
   localparam q_type Q_MIN        = 32'sh8000_0000;
   localparam q_type Q_ONE        = 32'sh0010_0000;
   localparam q_type Q_HALF_STEP  = 32'sh0008_0000;   // half of one, in raw LSBs

   // -------------------------------------------------------------------------
   // predictor and result checker
   // -------------------------------------------------------------------------
   class stiffness_tracker;
      q_type              mass [CELLS];
      q_type              inv_mass [CELLS];
      q_type              deriv [CELLS];
      q_type              product [CELLS];
      logic [SIZE_W-1:0]  size_reg;
      stiffness_elem_type due_elements [$];
      int                 errors;

      function new();
         size_reg = smp_pkg::SIZE_RESET;
         errors   = 0;
         foreach (mass[k]) begin
            mass[k]     = '0;
            inv_mass[k] = '0;
            deriv[k]    = '0;
            product[k]  = '0;
         end
      endfunction

      function void set_size(logic [SIZE_W-1:0] v);
         size_reg = v;
      endfunction

      // zero acts as one, anything above the store acts as the full size
      function int active_size();
         if (size_reg == 0) return 1;
         if (size_reg > MAX_SIZE) return MAX_SIZE;
         return int'(size_reg);
      endfunction

      function int pending();
         return due_elements.size();
      endfunction

      // exact sum of products, round half up to Q12.20, saturate
      function q_type rounded_dot(q_type a [MAX_SIZE], q_type b [MAX_SIZE], int n);
         logic signed [WIDE_W-1:0] term;
         logic signed [WIDE_W-1:0] sum;
         logic signed [WIDE_W-1:0] rnd;
         sum = '0;
         for (int k = 0; k < n; k++) begin
            term = a[k] * b[k];
            sum  = sum + term;
         end
         rnd = (sum + WIDE_W'(Q_HALF_STEP)) >>> FRAC_BITS;
         if (rnd > WIDE_W'(Q_MAX)) return Q_MAX;
         if (rnd < WIDE_W'(Q_MIN)) return Q_MIN;
         return q_type'(rnd[DATA_W-1:0]);
      endfunction

      function void note_transaction(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] row,
                                     logic [IDX_W-1:0] col, q_type value);
         int                 n;
         q_type              lhs [MAX_SIZE];
         q_type              rhs [MAX_SIZE];
         stiffness_elem_type e;
         case (cmd)
            smp_pkg::CMD_WRITE_MASS: begin
               mass[int'(row) * MAX_SIZE + int'(col)] = value;
               return;
            end
            smp_pkg::CMD_WRITE_INVMASS: begin
               inv_mass[int'(row) * MAX_SIZE + int'(col)] = value;
               return;
            end
            smp_pkg::CMD_WRITE_DERIV: begin
               deriv[int'(row) * MAX_SIZE + int'(col)] = value;
               return;
            end
            default: ;
         endcase
         n = active_size();
         // T = M * D
         for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
               for (int k = 0; k < MAX_SIZE; k++) begin
                  lhs[k] = mass[i * MAX_SIZE + k];
                  rhs[k] = deriv[k * MAX_SIZE + j];
               end
               product[i * MAX_SIZE + j] = rounded_dot(lhs, rhs, n);
            end
         end
         // S = Minv * T^T, row-major
         for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
               for (int k = 0; k < MAX_SIZE; k++) begin
                  lhs[k] = inv_mass[i * MAX_SIZE + k];
                  rhs[k] = product[j * MAX_SIZE + k];
               end
               e.row   = IDX_W'(i);
               e.col   = IDX_W'(j);
               e.value = rounded_dot(lhs, rhs, n);
               e.last  = (i == n - 1) && (j == n - 1);
               due_elements.push_back(e);
            end
         end
      endfunction

      function void check_element(stiffness_elem_type seen);
         stiffness_elem_type want;
         if (due_elements.size() == 0) begin
            $display("%0t: unexpected element row %0d col %0d value %0d", $time,
                     seen.row, seen.col, seen.value);
            errors++;
            return;
         end
         want = due_elements.pop_front();
         if (seen.row !== want.row) begin
            $display("%0t: out_row expected %0d actual %0d", $time, want.row, seen.row);
            errors++;
         end
         if (seen.col !== want.col) begin
            $display("%0t: out_col expected %0d actual %0d", $time, want.col, seen.col);
            errors++;
         end
         if (seen.value !== want.value) begin
            $display("%0t: out_value expected %0d actual %0d", $time, want.value,
                     seen.value);
            errors++;
         end
         if (seen.last !== want.last) begin
            $display("%0t: last expected %0d actual %0d", $time, want.last, seen.last);
            errors++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // block and its signals
   // -------------------------------------------------------------------------
   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [CMD_W-1:0]   req_command;
   logic [IDX_W-1:0]   req_row;
   logic [IDX_W-1:0]   req_col;
   q_type              req_value;
   logic               csr_wr_en;
   logic [SIZE_W-1:0]  csr_wr_data;
   logic               rsp_valid;
   logic [IDX_W-1:0]   rsp_out_row;
   logic [IDX_W-1:0]   rsp_out_col;
   q_type              rsp_out_value;
   logic               rsp_last;

   stiffness_tracker   tracker = new();
   int                 idle_cycles;
   int                 items_sent;
   bit                 burst;
   // which store entries hold a value, so no compute reads an unwritten one
   bit                 loaded [int'(smp_pkg::CMD_WRITE_DERIV) + 1][CELLS];

   stiffness_matrix_product DUT (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_command   (req_command),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_value     (req_value),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .rsp_valid     (rsp_valid),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_out_value (rsp_out_value),
      .rsp_last      (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // every rsp_valid pulse is one transaction, the block never waits on us
   always @(posedge clock) begin : rsp_monitor
      stiffness_elem_type seen;
      if (!reset && rsp_valid) begin
         seen.row   = rsp_out_row;
         seen.col   = rsp_out_col;
         seen.value = rsp_out_value;
         seen.last  = rsp_last;
         tracker.check_element(seen);
      end
   end

   // cycles since the last accepted request or emitted element
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : watchdog
      wait (idle_cycles >= LIMIT);
      $display("stiffness_matrix_product_tb failed");
      $finish;
   end

   // -------------------------------------------------------------------------
   // stimulus helpers
   // -------------------------------------------------------------------------

   // mostly values near one so results stay in range, some wide and extreme
   function automatic q_type pick_value();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         case ($urandom_range(0, 4))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3:       return -1;
            default: return Q_ONE;
         endcase
      end
      if (pick < 3) return q_type'($urandom);
      return q_type'($urandom_range(0, 32'h0080_0000)) - q_type'(32'h0040_0000);
   endfunction

   // one request transaction; start is held until the block takes it
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] row,
                            input logic [IDX_W-1:0] col, input q_type value);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 5);
      @(negedge clock);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start       <= 1'b1;
      req_command <= cmd;
      req_row     <= row;
      req_col     <= col;
      req_value   <= value;
      do @(posedge clock); while (busy);
      tracker.note_transaction(cmd, row, col, value);
      if (cmd != smp_pkg::CMD_COMPUTE) loaded[cmd][int'(row) * MAX_SIZE + int'(col)] = 1'b1;
      items_sent++;
   endtask

   // drop start and hold off until every predicted element has come out
   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   // size changes only while the block is idle
   task automatic write_size(input logic [SIZE_W-1:0] v);
      wait_drained();
      while (busy) @(posedge clock);
      repeat (CFG_SETTLE) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      tracker.set_size(v);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // test sequence
   // -------------------------------------------------------------------------
   initial begin
      int                seq_idx;
      int                n;
      int                pick;
      logic [SIZE_W-1:0] size_sel;

      reset       = 1'b1;
      start       = 1'b0;
      req_command = smp_pkg::CMD_WRITE_MASS;
      req_row     = '0;
      req_col     = '0;
      req_value   = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      items_sent  = 0;
      burst       = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: single-element matrices hit saturation and rounding
      write_size(SIZE_W'(1));
      send_item(smp_pkg::CMD_WRITE_MASS, '0, '0, Q_MAX);
      send_item(smp_pkg::CMD_WRITE_INVMASS, '0, '0, Q_MAX);
      send_item(smp_pkg::CMD_WRITE_DERIV, '0, '0, Q_MAX);
      // compute ignores its position and value fields
      send_item(smp_pkg::CMD_COMPUTE, IDX_W'(7), IDX_W'(7), Q_MIN);
      // negative overflow in T and again in S
      send_item(smp_pkg::CMD_WRITE_DERIV, '0, '0, Q_MIN);
      send_item(smp_pkg::CMD_COMPUTE, IDX_W'(5), IDX_W'(2), -1);
      // min times min overflows positive
      send_item(smp_pkg::CMD_WRITE_MASS, '0, '0, Q_MIN);
      send_item(smp_pkg::CMD_COMPUTE, '0, '0, '0);
      // exactly half an lsb rounds up
      send_item(smp_pkg::CMD_WRITE_MASS, '0, '0, 32'sd1);
      send_item(smp_pkg::CMD_WRITE_DERIV, '0, '0, Q_HALF_STEP);
      send_item(smp_pkg::CMD_WRITE_INVMASS, '0, '0, Q_ONE);
      send_item(smp_pkg::CMD_COMPUTE, '0, '0, '0);
      // negative half lands on zero, minus one and a half on minus one
      send_item(smp_pkg::CMD_WRITE_MASS, '0, '0, -1);
      send_item(smp_pkg::CMD_COMPUTE, '0, '0, '0);
      send_item(smp_pkg::CMD_WRITE_MASS, '0, '0, -3);
      send_item(smp_pkg::CMD_COMPUTE, '0, '0, '0);
      // write outside the active size is kept for later
      send_item(smp_pkg::CMD_WRITE_MASS, IDX_W'(7), IDX_W'(7), Q_ONE);
      send_item(smp_pkg::CMD_WRITE_DERIV, IDX_W'(3), IDX_W'(6), -Q_ONE);

      // random: load sequences with random content, then compute
      seq_idx = 0;
      while (items_sent < TARGET_ITEMS) begin
         // force the size extremes early, then change size now and then
         if (seq_idx == 2) begin
            write_size(SIZE_W'(15));
         end else if (seq_idx == 5) begin
            write_size(SIZE_W'(0));
         end else if (seq_idx == 9) begin
            write_size(SIZE_W'(MAX_SIZE));
         end else if ($urandom_range(0, 3) == 0) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) size_sel = SIZE_W'($urandom_range(9, 15));
            else if (pick < 3) size_sel = SIZE_W'($urandom_range(5, 8));
            else size_sel = SIZE_W'($urandom_range(1, 4));
            write_size(size_sel);
         end
         burst = ($urandom_range(0, 3) == 0);
         n = tracker.active_size();

         // stray loads anywhere in the stores
         repeat ($urandom_range(0, 3)) begin
            send_item(CMD_W'($urandom_range(smp_pkg::CMD_WRITE_MASS,
                                            smp_pkg::CMD_WRITE_DERIV)),
                      IDX_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 7)),
                      pick_value());
         end
         // refresh some entries inside the active size
         repeat ($urandom_range(0, n * n / 2)) begin
            send_item(CMD_W'($urandom_range(smp_pkg::CMD_WRITE_MASS,
                                            smp_pkg::CMD_WRITE_DERIV)),
                      IDX_W'($urandom_range(0, n - 1)), IDX_W'($urandom_range(0, n - 1)),
                      pick_value());
         end
         // fill whatever the compute would read and was never loaded
         for (int m = smp_pkg::CMD_WRITE_MASS; m <= smp_pkg::CMD_WRITE_DERIV; m++) begin
            for (int r = 0; r < n; r++) begin
               for (int c = 0; c < n; c++) begin
                  if (!loaded[m][r * MAX_SIZE + c]) begin
                     send_item(CMD_W'(m), IDX_W'(r), IDX_W'(c), pick_value());
                  end
               end
            end
         end

         send_item(smp_pkg::CMD_COMPUTE, IDX_W'($urandom_range(0, 7)),
                   IDX_W'($urandom_range(0, 7)), pick_value());
         // back-to-back compute on unchanged matrices
         if ($urandom_range(0, 9) == 0) begin
            send_item(smp_pkg::CMD_COMPUTE, IDX_W'($urandom_range(0, 7)),
                      IDX_W'($urandom_range(0, 7)), pick_value());
         end
         // sender holds off until the stream has fully drained
         if (seq_idx == 1 || $urandom_range(0, 4) == 0) wait_drained();
         seq_idx++;
      end

      wait_drained();
      repeat (END_WAIT) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("stiffness_matrix_product_tb passed");
      end else begin
         $display("stiffness_matrix_product_tb failed");
      end
      $finish;
   end

endmodule
